/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expr must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* hdl/ckbb_pkg.sv */
// ----------------------------------------------------------------------------
// ckbb_pkg
// Types and constants of the color key bounding box block.
// ----------------------------------------------------------------------------
package ckbb_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int COLOR_BITS = 24;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int SIZE_W     = DIM_W + 1;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

	localparam logic [COLOR_W-1:0] KEY_COLOR_RST    = 24'hFF00FF;
	localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = SIZE_W'(MAX_DIM);
	localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = SIZE_W'(MAX_DIM);
	localparam logic [DIM_W-1:0]   DIM_MAX          = DIM_W'(MAX_DIM - 1);

	typedef struct packed {
		logic [DIM_W-1:0]   pixel_x;
		logic [DIM_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               frame_end;
		logic               image_end;
	} pix_t;

	typedef struct packed {
		logic [SIZE_W-1:0] box_left;
		logic [SIZE_W-1:0] box_top;
		logic [SIZE_W-1:0] box_width;
		logic [SIZE_W-1:0] box_height;
		logic              found_any;
	} box_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

endpackage

/* hdl/ckbb_if.sv */
// ----------------------------------------------------------------------------
// ckbb channel interfaces
// Valid/ready channels for pixel words, result words and register writes.
// ----------------------------------------------------------------------------
interface ckbb_pix_if;
	logic          valid;
	logic          ready;
	ckbb_pkg::pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ckbb_box_if;
	logic          valid;
	logic          ready;
	ckbb_pkg::box_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ckbb_cfg_if;
	logic          valid;
	logic          ready;
	ckbb_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/color_key_bounding_box_top.sv */
// ----------------------------------------------------------------------------
// color_key_bounding_box_top
// Opaque bounding box over a set of color-keyed sprite frames.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock unless a word waits as described below. A
// word enters an input register; from there its box update and frame fold
// run in one pass against the state registers, and an image end loads the
// result register. Pixel words keep flowing while a result waits to be taken;
// only an image-end pixel that finds the result register still full waits in
// the input register. Register writes are taken at any time and are meant for
// an idle block.
`include "assert_macros.svh"

module color_key_bounding_box_top (
	input  logic       clk,
	input  logic       arst_n,
	ckbb_pix_if.sink   pix,
	ckbb_box_if.source res,
	ckbb_cfg_if.sink   cfg
);

	// configuration registers
	logic [ckbb_pkg::COLOR_W-1:0] key_color_q;
	logic [ckbb_pkg::SIZE_W-1:0]  frame_width_q;
	logic [ckbb_pkg::SIZE_W-1:0]  frame_height_q;

	// input stage
	logic           valid_s1;
	ckbb_pkg::pix_t pix_s1;
	logic           fire_s1;

	// frame and running box state
	logic [ckbb_pkg::DIM_W-1:0]  frame_left_q, frame_right_q, frame_top_q, frame_bottom_q;
	logic                        frame_nonempty_q;
	logic [ckbb_pkg::SIZE_W-1:0] total_left_q, total_top_q, total_width_q, total_height_q;
	logic                        total_nonempty_q;

	// result register
	logic           out_valid_q;
	ckbb_pkg::box_t out_q;

	// single pass logic
	logic                        hit;
	logic                        fold;
	logic [ckbb_pkg::DIM_W-1:0]  nl, nr, nt, nb;
	logic                        nne;
	logic [ckbb_pkg::SIZE_W-1:0] fw, fh;
	logic [ckbb_pkg::SIZE_W-1:0] tl, tt, tw, th;
	logic                        tne;
	ckbb_pkg::box_t              result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_color_q    <= ckbb_pkg::KEY_COLOR_RST;
			frame_width_q  <= ckbb_pkg::FRAME_WIDTH_RST;
			frame_height_q <= ckbb_pkg::FRAME_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				ckbb_pkg::CFG_KEY_COLOR: begin
					key_color_q <= cfg.data.wdata[ckbb_pkg::COLOR_W-1:0];
				end
				ckbb_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg.data.wdata[ckbb_pkg::SIZE_W-1:0];
				end
				ckbb_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg.data.wdata[ckbb_pkg::SIZE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign fire_s1   = valid_s1 && (!pix_s1.image_end || !out_valid_q || res.ready);
	assign pix.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pix_s1 <= pix.data;
		end
	end

	always_comb begin
		hit = ({1'b0, pix_s1.pixel_x} < frame_width_q)
			&& ({1'b0, pix_s1.pixel_y} < frame_height_q)
			&& (pix_s1.pixel_color[ckbb_pkg::COLOR_BITS-1:0]
				!= key_color_q[ckbb_pkg::COLOR_BITS-1:0]);
		nl  = (hit && pix_s1.pixel_x < frame_left_q)   ? pix_s1.pixel_x : frame_left_q;
		nr  = (hit && pix_s1.pixel_x > frame_right_q)  ? pix_s1.pixel_x : frame_right_q;
		nt  = (hit && pix_s1.pixel_y < frame_top_q)    ? pix_s1.pixel_y : frame_top_q;
		nb  = (hit && pix_s1.pixel_y > frame_bottom_q) ? pix_s1.pixel_y : frame_bottom_q;
		nne = frame_nonempty_q || hit;
		fw  = {1'b0, nr} - {1'b0, nl} + ckbb_pkg::SIZE_W'(1);
		fh  = {1'b0, nb} - {1'b0, nt} + ckbb_pkg::SIZE_W'(1);
		fold = pix_s1.frame_end || pix_s1.image_end;

		tl  = total_left_q;
		tt  = total_top_q;
		tw  = total_width_q;
		th  = total_height_q;
		tne = total_nonempty_q;
		if (fold && nne) begin
			if (!total_nonempty_q) begin
				tl = {1'b0, nl};
				tt = {1'b0, nt};
				tw = fw;
				th = fh;
			end else begin
				if ({1'b0, nl} < total_left_q) tl = {1'b0, nl};
				if ({1'b0, nt} < total_top_q)  tt = {1'b0, nt};
				if (fw > total_width_q)        tw = fw;
				if (fh > total_height_q)       th = fh;
			end
			tne = 1'b1;
		end

		if (tne) begin
			result = '{box_left: tl, box_top: tt, box_width: tw, box_height: th,
				found_any: 1'b1};
		end else begin
			result = '{box_left: frame_width_q, box_top: frame_height_q,
				box_width: '0, box_height: '0, found_any: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_left_q     <= ckbb_pkg::DIM_MAX;
			frame_right_q    <= '0;
			frame_top_q      <= ckbb_pkg::DIM_MAX;
			frame_bottom_q   <= '0;
			frame_nonempty_q <= 1'b0;
			total_left_q     <= ckbb_pkg::FRAME_WIDTH_RST;
			total_top_q      <= ckbb_pkg::FRAME_HEIGHT_RST;
			total_width_q    <= '0;
			total_height_q   <= '0;
			total_nonempty_q <= 1'b0;
		end else if (fire_s1) begin
			if (fold) begin
				frame_left_q     <= ckbb_pkg::DIM_MAX;
				frame_right_q    <= '0;
				frame_top_q      <= ckbb_pkg::DIM_MAX;
				frame_bottom_q   <= '0;
				frame_nonempty_q <= 1'b0;
			end else begin
				frame_left_q     <= nl;
				frame_right_q    <= nr;
				frame_top_q      <= nt;
				frame_bottom_q   <= nb;
				frame_nonempty_q <= nne;
			end
			if (pix_s1.image_end) begin
				total_left_q     <= frame_width_q;
				total_top_q      <= frame_height_q;
				total_width_q    <= '0;
				total_height_q   <= '0;
				total_nonempty_q <= 1'b0;
			end else begin
				total_left_q     <= tl;
				total_top_q      <= tt;
				total_width_q    <= tw;
				total_height_q   <= th;
				total_nonempty_q <= tne;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && pix_s1.image_end) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && pix_s1.image_end) begin
			out_q <= result;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	`ASSERT_PROP(a_found_has_size, out_valid_q && out_q.found_any |-> out_q.box_width != '0 && out_q.box_height != '0, "found box with zero size")
	`ASSERT_PROP(a_empty_no_size, out_valid_q && !out_q.found_any |-> out_q.box_width == '0 && out_q.box_height == '0, "empty result with size")
	`ASSERT_PROP(a_end_loads_result, fire_s1 && pix_s1.image_end |=> out_valid_q, "image end without result")
	`ASSERT_PROP(a_end_clears_state, fire_s1 && pix_s1.image_end |=> !frame_nonempty_q && !total_nonempty_q, "state not cleared at image end")
	`ASSERT_NEVER(a_frame_box_order, frame_nonempty_q && (frame_left_q > frame_right_q || frame_top_q > frame_bottom_q), "frame box inverted")

endmodule
